// ===== src/stg_pkg.sv =====
`timescale 1ns / 1ps
package stg_pkg;

  localparam int unsigned MAX_FRAMES     = 64;
  localparam int unsigned PHASE_BITS     = 32;
  localparam int unsigned SINE_ADDR_BITS = 10;

  localparam int unsigned PITCH_W  = 31;
  localparam int unsigned FRAME_W  = 7;
  localparam int unsigned GAIN_W   = 16;
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned Q15_W    = 16;

  localparam int unsigned FCNT_W   = $clog2(MAX_FRAMES + 1);
  localparam int unsigned STEP_W   = $clog2(PITCH_W);
  localparam int unsigned QUAD_W   = SINE_ADDR_BITS - 2;
  localparam int unsigned X_SHIFT  = 15 - QUAD_W;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [Q15_W-1:0]  POLY_A      = 16'd51472;
  localparam logic [Q15_W-1:0]  POLY_B      = 16'd21165;
  localparam logic [Q15_W-1:0]  POLY_C      = 16'd2461;
  localparam logic [Q15_W-1:0]  FULL_SCALE  = 16'd32767;
  localparam logic [GAIN_W-1:0] GAIN_RESET  = 16'd32768;

  typedef struct packed {
    logic [PHASE_BITS-1:0] start_inc;
    logic [PHASE_BITS-1:0] delta;
    logic [FCNT_W-1:0]     count;
  } job_t;

  typedef enum logic [2:0] {
    FS_IDLE = 3'b001,
    FS_DIV  = 3'b010,
    FS_PUSH = 3'b100
  } front_state_e;

endpackage

// ===== src/stg_ifs.sv =====
`timescale 1ns / 1ps
interface stg_in_if;
  import stg_pkg::*;
  logic               valid;
  logic               ready;
  logic [PITCH_W-1:0] pitch_step;
  logic [FRAME_W-1:0] buf_frames;
  modport source (output valid, pitch_step, buf_frames, input ready);
  modport sink (input valid, pitch_step, buf_frames, output ready);
endinterface

interface stg_out_if;
  import stg_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       last;
  modport source (output valid, sample, last, input ready);
  modport sink (input valid, sample, last, output ready);
endinterface

interface stg_cfg_if;
  import stg_pkg::*;
  logic              valid;
  logic              ready;
  logic [GAIN_W-1:0] volume_gain;
  modport source (output valid, volume_gain, input ready);
  modport sink (input valid, volume_gain, output ready);
endinterface

// ===== src/sine_tone_generator_glide_top.sv =====
`timescale 1ns / 1ps
// sine oscillator with pitch glide: each request transaction asks for one buffer of buf_frames
// samples (1..64, larger counts clamp to 64, zero is dropped) at a target phase step. the front
// end works out the per-sample glide step with a one-bit-per-cycle divider while the back end
// loads the previous buffer's job and streams it at one sample per cycle whenever the sink does
// not stall, behind a two-entry job queue and a sine/gain pipeline. volume_gain resets to unity
// (32768) and is written through the config channel, which is always ready.
module sine_tone_generator_glide_top (
  input  logic      clk_i,
  input  logic      rst_ni,
  stg_in_if.sink    req_i,
  stg_cfg_if.sink   cfg_i,
  stg_out_if.source smp_o
);
  import stg_pkg::*;

  logic [GAIN_W-1:0] gain_q;
  job_t              front_job, back_job;
  logic              front_valid, queue_ready, queue_valid, back_pop;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= GAIN_RESET;
    end else if (cfg_i.valid) begin
      gain_q <= cfg_i.volume_gain;
    end
  end

  stg_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .job_o       (front_job),
    .job_valid_o (front_valid),
    .job_ready_i (queue_ready)
  );

  stg_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (front_valid),
    .push_ready_o (queue_ready),
    .push_job_i   (front_job),
    .pop_valid_o  (queue_valid),
    .pop_i        (back_pop),
    .pop_job_o    (back_job)
  );

  stg_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (back_job),
    .job_valid_i (queue_valid),
    .pop_o       (back_pop),
    .gain_i      (gain_q),
    .smp_o       (smp_o)
  );

endmodule

// ===== src/stg_front.sv =====
`timescale 1ns / 1ps
module stg_front (
  input  logic         clk_i,
  input  logic         rst_ni,
  stg_in_if.sink       req_i,
  output stg_pkg::job_t job_o,
  output logic         job_valid_o,
  input  logic         job_ready_i
);
  import stg_pkg::*;

  front_state_e         state_q, state_d;
  logic [PITCH_W-1:0]   prev_q, prev_d;
  logic                 has_prev_q, has_prev_d;
  logic [FCNT_W-1:0]    n_q, n_d;
  logic [PHASE_BITS-1:0] start_q, start_d;
  logic                 neg_q, neg_d;
  logic [PITCH_W-1:0]   dq_q, dq_d;
  logic [FCNT_W-1:0]    rem_q, rem_d;
  logic [STEP_W-1:0]    step_q, step_d;

  logic                 accept;
  logic [FCNT_W-1:0]    n_sat;
  logic [FCNT_W:0]      shifted;
  logic                 ge;
  logic [PHASE_BITS-1:0] q_ext;

  assign req_i.ready = (state_q == FS_IDLE);
  assign accept      = req_i.valid && req_i.ready && (req_i.buf_frames != '0);
  assign n_sat       = (32'(req_i.buf_frames) > MAX_FRAMES) ? FCNT_W'(MAX_FRAMES)
                                                            : FCNT_W'(req_i.buf_frames);
  assign shifted     = {rem_q, dq_q[PITCH_W-1]};
  assign ge          = shifted >= {1'b0, n_q};
  assign q_ext       = PHASE_BITS'(dq_q);

  assign job_valid_o     = (state_q == FS_PUSH);
  assign job_o.start_inc = start_q;
  assign job_o.delta     = neg_q ? PHASE_BITS'(~q_ext + 1'b1) : q_ext;
  assign job_o.count     = n_q;

  always_comb begin
    state_d    = state_q;
    prev_d     = prev_q;
    has_prev_d = has_prev_q;
    n_d        = n_q;
    start_d    = start_q;
    neg_d      = neg_q;
    dq_d       = dq_q;
    rem_d      = rem_q;
    step_d     = step_q;
    unique case (state_q)
      FS_IDLE: begin
        if (accept) begin
          n_d        = n_sat;
          rem_d      = '0;
          step_d     = STEP_W'(PITCH_W - 1);
          prev_d     = req_i.pitch_step;
          has_prev_d = 1'b1;
          if (has_prev_q) begin
            start_d = PHASE_BITS'(prev_q);
            neg_d   = req_i.pitch_step < prev_q;
            dq_d    = neg_d ? (prev_q - req_i.pitch_step) : (req_i.pitch_step - prev_q);
          end else begin
            start_d = PHASE_BITS'(req_i.pitch_step);
            neg_d   = 1'b0;
            dq_d    = '0;
          end
          state_d = FS_DIV;
        end
      end
      FS_DIV: begin
        rem_d  = ge ? FCNT_W'(shifted - {1'b0, n_q}) : FCNT_W'(shifted);
        dq_d   = {dq_q[PITCH_W-2:0], ge};
        step_d = step_q - 1'b1;
        if (step_q == '0) begin
          state_d = FS_PUSH;
        end
      end
      FS_PUSH: begin
        if (job_ready_i) begin
          state_d = FS_IDLE;
        end
      end
      default: state_d = FS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= FS_IDLE;
      prev_q     <= '0;
      has_prev_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      prev_q     <= prev_d;
      has_prev_q <= has_prev_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q     <= n_d;
    start_q <= start_d;
    neg_q   <= neg_d;
    dq_q    <= dq_d;
    rem_q   <= rem_d;
    step_q  <= step_d;
  end

  a_rem_below_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == FS_DIV |-> rem_q < n_q)
    else $error("division remainder not below frame count");

  a_div_ends_in_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == FS_DIV && step_q == '0 |=> state_q == FS_PUSH)
    else $error("division did not hand over to push");

endmodule

// ===== src/stg_queue.sv =====
`timescale 1ns / 1ps
module stg_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  stg_pkg::job_t push_job_i,
  output logic          pop_valid_o,
  input  logic          pop_i,
  output stg_pkg::job_t pop_job_o
);
  import stg_pkg::*;

  job_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              push, pop;

  assign push_ready_o = cnt_q != QCNT_W'(QUEUE_DEPTH);
  assign pop_valid_o  = cnt_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_i && pop_valid_o;
  assign pop_job_o    = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      cnt_q <= cnt_q + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

  a_cnt_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue fill count beyond depth");

  a_pop_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> cnt_q != '0)
    else $error("pop from empty queue");

endmodule

// ===== src/stg_back.sv =====
`timescale 1ns / 1ps
module stg_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  stg_pkg::job_t             job_i,
  input  logic                      job_valid_i,
  output logic                      pop_o,
  input  logic [stg_pkg::GAIN_W-1:0] gain_i,
  stg_out_if.source                 smp_o
);
  import stg_pkg::*;

  localparam int unsigned PIPE_N = 6;

  logic [PHASE_BITS-1:0] phase_q, inc_q, delta_q;
  logic [FCNT_W-1:0]     remaining_q;
  logic                  load, issue, adv;

  logic [PIPE_N-1:0]     vld_q, last_q, neg_q;

  logic [SINE_ADDR_BITS-1:0] addr;
  logic [QUAD_W:0]           idx_adj;
  logic [Q15_W-1:0]          x0;

  logic [Q15_W-1:0] x1_q, x2x_q, x2_q, x3_q, x2b_q, t1_q, x4_q, t2_q;
  logic [16:0]      s_q;
  logic [17:0]      m_q;

  logic [31:0] p_xx, p_cx, p_tx;
  logic [32:0] p_sx;
  logic [33:0] p_sg;
  logic [32:0] p_mf;
  logic [17:0] mag;
  logic [Q15_W-1:0] mag_sat;

  logic                out_valid_q;
  logic [SAMPLE_W-1:0] sample_q;
  logic                out_last_q;

  assign adv   = !out_valid_q || smp_o.ready;
  assign load  = (remaining_q == '0) && job_valid_i;
  assign pop_o = load;
  assign issue = (remaining_q != '0) && adv;

  assign addr    = phase_q[PHASE_BITS-1 -: SINE_ADDR_BITS];
  assign idx_adj = addr[QUAD_W] ? ((QUAD_W+1)'(1) << QUAD_W) - {1'b0, addr[QUAD_W-1:0]}
                                : {1'b0, addr[QUAD_W-1:0]};
  assign x0      = Q15_W'({idx_adj, {X_SHIFT{1'b0}}});

  assign p_xx    = 32'(x1_q) * 32'(x1_q);
  assign p_cx    = 32'(POLY_C) * 32'(x2_q);
  assign p_tx    = 32'(t1_q) * 32'(x2b_q);
  assign p_sx    = 33'(t2_q) * 33'(x4_q);
  assign p_sg    = 34'(s_q) * 34'(gain_i);
  assign p_mf    = 33'(m_q) * 33'(FULL_SCALE);
  assign mag     = p_mf[32:15];
  assign mag_sat = (mag > 18'(FULL_SCALE)) ? FULL_SCALE : mag[Q15_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= '0;
      inc_q       <= '0;
      delta_q     <= '0;
      remaining_q <= '0;
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        inc_q       <= job_i.start_inc;
        delta_q     <= job_i.delta;
        remaining_q <= job_i.count;
      end else if (issue) begin
        phase_q     <= phase_q + inc_q;
        inc_q       <= inc_q + delta_q;
        remaining_q <= remaining_q - 1'b1;
      end
      if (adv) begin
        vld_q       <= {vld_q[PIPE_N-2:0], issue};
        out_valid_q <= vld_q[PIPE_N-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      last_q     <= {last_q[PIPE_N-2:0], remaining_q == FCNT_W'(1)};
      neg_q      <= {neg_q[PIPE_N-2:0], addr[SINE_ADDR_BITS-1]};
      x1_q       <= x0;
      x2x_q      <= x1_q;
      x2_q       <= p_xx[30:15];
      x3_q       <= x2x_q;
      x2b_q      <= x2_q;
      t1_q       <= POLY_B - p_cx[30:15];
      x4_q       <= x3_q;
      t2_q       <= POLY_A - p_tx[30:15];
      s_q        <= p_sx[31:15];
      m_q        <= p_sg[32:15];
      sample_q   <= neg_q[PIPE_N-1] ? SAMPLE_W'(~mag_sat + 1'b1) : SAMPLE_W'(mag_sat);
      out_last_q <= last_q[PIPE_N-1];
    end
  end

  assign smp_o.valid  = out_valid_q;
  assign smp_o.sample = $signed(sample_q);
  assign smp_o.last   = out_last_q;

  a_load_gives_frames: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> remaining_q != '0)
    else $error("job loaded without frames");

endmodule
